// ===== rtl/scfp_pkg.sv =====
// Shared types, constants and codes for the serial command frame parser.
package scfp_pkg;

	localparam int MAX_DATA_BYTES_DEF = 22;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 5;
	localparam int WIDTH_W = 2;
	localparam int INDEX_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 32;

	localparam logic [KIND_W-1:0] EV_DATA    = 2'd0;
	localparam logic [KIND_W-1:0] EV_CLEAR   = 2'd1;
	localparam logic [KIND_W-1:0] EV_DISCARD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENDING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd2;

	localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
	localparam logic [BYTE_W-1:0] ENDING_RST = 8'h55;
	localparam logic [BYTE_W-1:0] CLEAR_RST  = 8'h00;

	localparam logic [BYTE_W-1:0] COUNT_SHORT  = 8'd1;
	localparam logic [BYTE_W-1:0] COUNT_PAIR   = 8'd2;
	localparam logic [BYTE_W-1:0] COUNT_LONG   = 8'd22;
	localparam logic [BYTE_W-1:0] WIDTH_LIMIT  = 8'd2;
	localparam logic [COUNT_W-1:0] CLEAR_COUNT = 5'd1;
	localparam logic [WIDTH_W-1:0] CLEAR_WIDTH = 2'd1;

	typedef struct packed {
		logic frame_start;
		logic take_reg;
		logic take_count;
		logic take_width;
		logic take_data;
		logic emit_start;
		logic emit_clear;
		logic emit_load;
		logic discard;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hdr_match;
		logic count_ok;
		logic width_ok;
		logic end_ok;
		logic clear_hit;
		logic clear_shape_ok;
		logic fill_done;
		logic emit_last;
		logic pre_ready;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/scfp_ctrl.sv =====
// Frame parse sequencer: phase state machine that drives the datapath commands.
module scfp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  scfp_pkg::dp_status_t  sts,
	output scfp_pkg::ctrl_cmd_t   cmd
);

	localparam logic [2:0] ST_HUNT  = 3'd0;
	localparam logic [2:0] ST_REG   = 3'd1;
	localparam logic [2:0] ST_COUNT = 3'd2;
	localparam logic [2:0] ST_WIDTH = 3'd3;
	localparam logic [2:0] ST_DATA  = 3'd4;
	localparam logic [2:0] ST_END   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       fire;

	always_comb begin
		unique case (state_q) inside
			ST_EMIT:                     s_tready = 1'b0;
			ST_COUNT, ST_WIDTH, ST_END:  s_tready = sts.out_free;
			default:                     s_tready = 1'b1;
		endcase
	end

	assign fire = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (fire && sts.hdr_match) begin
					cmd.frame_start = 1'b1;
					state_d = ST_REG;
				end
			end
			ST_REG: begin
				if (fire) begin
					cmd.take_reg = 1'b1;
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				if (fire) begin
					if (sts.count_ok) begin
						cmd.take_count = 1'b1;
						state_d = ST_WIDTH;
					end else begin
						cmd.discard = 1'b1;
						state_d = ST_HUNT;
					end
				end
			end
			ST_WIDTH: begin
				if (fire) begin
					if (sts.width_ok) begin
						cmd.take_width = 1'b1;
						state_d = ST_DATA;
					end else begin
						cmd.discard = 1'b1;
						state_d = ST_HUNT;
					end
				end
			end
			ST_DATA: begin
				if (fire) begin
					cmd.take_data = 1'b1;
					if (sts.fill_done) begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				if (fire) begin
					if (!sts.end_ok || (sts.clear_hit && !sts.clear_shape_ok)) begin
						cmd.discard = 1'b1;
						state_d = ST_HUNT;
					end else begin
						cmd.emit_start = 1'b1;
						cmd.emit_clear = sts.clear_hit;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.pre_ready && sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_HUNT;
					end
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> !s_tready)
		else $error("input accepted during result burst");
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_load || cmd.discard) |-> sts.out_free)
		else $error("output register overwritten");
	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && cmd.emit_load && sts.emit_last) |=> state_q == ST_HUNT)
		else $error("burst end did not return to hunting");
`endif

endmodule

// ===== rtl/scfp_datapath.sv =====
// Frame datapath: config registers, held header fields, data buffer, output register.
module scfp_datapath #(
	parameter int MAX_DATA_BYTES = scfp_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [scfp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [scfp_pkg::BYTE_W-1:0]            cfg_data,
	input  logic [scfp_pkg::BYTE_W-1:0]            rx_byte,
	input  scfp_pkg::ctrl_cmd_t                    cmd,
	output scfp_pkg::dp_status_t                   sts,
	input  logic                                   m_tready,
	output logic                                   m_tvalid,
	output logic [scfp_pkg::KIND_W-1:0]            ev_kind,
	output logic [scfp_pkg::BYTE_W-1:0]            ev_register,
	output logic [scfp_pkg::COUNT_W-1:0]           ev_count,
	output logic [scfp_pkg::WIDTH_W-1:0]           ev_width,
	output logic [scfp_pkg::INDEX_W-1:0]           ev_index,
	output logic [scfp_pkg::BYTE_W-1:0]            ev_value,
	output logic                                   ev_last
);

	localparam int AW = $clog2(MAX_DATA_BYTES);

	logic [scfp_pkg::BYTE_W-1:0]  header_q, ending_q, clear_q;
	logic [scfp_pkg::BYTE_W-1:0]  held_reg_q;
	logic [scfp_pkg::COUNT_W-1:0] held_count_q;
	logic [scfp_pkg::WIDTH_W-1:0] held_width_q;
	logic [scfp_pkg::INDEX_W-1:0] fill_q;
	logic [scfp_pkg::INDEX_W-1:0] n_q;
	logic                         pre_q;
	logic [scfp_pkg::KIND_W-1:0]  emit_kind_q;

	logic [scfp_pkg::BYTE_W-1:0]  mem [MAX_DATA_BYTES];
	logic [scfp_pkg::BYTE_W-1:0]  rd_data_q;
	logic [AW-1:0]                rd_addr;
	logic [scfp_pkg::INDEX_W-1:0] n_next;

	logic                         out_valid_q;
	logic [scfp_pkg::KIND_W-1:0]  out_kind_q;
	logic [scfp_pkg::BYTE_W-1:0]  out_reg_q;
	logic [scfp_pkg::COUNT_W-1:0] out_count_q;
	logic [scfp_pkg::WIDTH_W-1:0] out_width_q;
	logic [scfp_pkg::INDEX_W-1:0] out_index_q;
	logic [scfp_pkg::BYTE_W-1:0]  out_value_q;
	logic                         out_last_q;

	// Status toward the sequencer
	assign sts.hdr_match = rx_byte == header_q;
	assign sts.count_ok  = (rx_byte == scfp_pkg::COUNT_SHORT || rx_byte == scfp_pkg::COUNT_PAIR
		|| rx_byte == scfp_pkg::COUNT_LONG) && (rx_byte <= scfp_pkg::BYTE_W'(MAX_DATA_BYTES));
	assign sts.width_ok  = rx_byte <= scfp_pkg::WIDTH_LIMIT;
	assign sts.end_ok    = rx_byte == ending_q;
	assign sts.clear_hit = held_reg_q == clear_q;
	assign sts.clear_shape_ok = held_count_q == scfp_pkg::CLEAR_COUNT
		&& held_width_q == scfp_pkg::CLEAR_WIDTH;
	assign sts.fill_done = ({1'b0, fill_q} + 6'd1) >= {1'b0, held_count_q};
	assign sts.emit_last = ({1'b0, n_q} + 6'd1) == {1'b0, held_count_q};
	assign sts.pre_ready = pre_q;
	assign sts.out_free  = !out_valid_q || m_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= scfp_pkg::HEADER_RST;
			ending_q <= scfp_pkg::ENDING_RST;
			clear_q  <= scfp_pkg::CLEAR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				scfp_pkg::CFG_HEADER: header_q <= cfg_data;
				scfp_pkg::CFG_ENDING: ending_q <= cfg_data;
				scfp_pkg::CFG_CLEAR:  clear_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held frame fields and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_reg_q   <= '0;
			held_count_q <= '0;
			held_width_q <= '0;
			fill_q       <= '0;
			n_q          <= '0;
			pre_q        <= 1'b0;
			emit_kind_q  <= scfp_pkg::EV_DATA;
		end else begin
			if (cmd.frame_start) begin
				held_reg_q   <= '0;
				held_count_q <= '0;
				held_width_q <= '0;
				fill_q       <= '0;
			end
			if (cmd.take_reg) begin
				held_reg_q <= rx_byte;
			end
			if (cmd.take_count) begin
				held_count_q <= rx_byte[scfp_pkg::COUNT_W-1:0];
			end
			if (cmd.take_width) begin
				held_width_q <= rx_byte[scfp_pkg::WIDTH_W-1:0];
				fill_q       <= '0;
			end
			if (cmd.take_data) begin
				fill_q <= fill_q + 5'd1;
			end
			if (cmd.emit_start) begin
				n_q         <= '0;
				pre_q       <= 1'b0;
				emit_kind_q <= cmd.emit_clear ? scfp_pkg::EV_CLEAR : scfp_pkg::EV_DATA;
			end else begin
				pre_q <= 1'b1;
				if (cmd.emit_load) begin
					n_q <= n_next;
				end
			end
		end
	end

	// Prefetch the entry after the one being loaded so results go out back to back
	assign n_next  = n_q + 5'd1;
	assign rd_addr = cmd.emit_load ? AW'(n_next) : AW'(n_q);

	always_ff @(posedge clk) begin
		if (cmd.take_data) begin
			mem[AW'(fill_q)] <= rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.discard || cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.discard) begin
			out_kind_q  <= scfp_pkg::EV_DISCARD;
			out_reg_q   <= held_reg_q;
			out_count_q <= held_count_q;
			out_width_q <= held_width_q;
			out_index_q <= '0;
			out_value_q <= rx_byte;
			out_last_q  <= 1'b1;
		end else if (cmd.emit_load) begin
			out_kind_q  <= emit_kind_q;
			out_reg_q   <= held_reg_q;
			out_count_q <= held_count_q;
			out_width_q <= held_width_q;
			out_index_q <= n_q;
			out_value_q <= rd_data_q;
			out_last_q  <= sts.emit_last;
		end
	end

	assign m_tvalid    = out_valid_q;
	assign ev_kind     = out_kind_q;
	assign ev_register = out_reg_q;
	assign ev_count    = out_count_q;
	assign ev_width    = out_width_q;
	assign ev_index    = out_index_q;
	assign ev_value    = out_value_q;
	assign ev_last     = out_last_q;

`ifndef SYNTHESIS
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_data |-> fill_q < held_count_q)
		else $error("data byte beyond declared count");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> n_q < held_count_q)
		else $error("result index beyond declared count");
	a_emit_after_prefetch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_start |=> !cmd.emit_load)
		else $error("result loaded before buffer read returned");
`endif

endmodule

// ===== rtl/serial_command_frame_parser.sv =====
// Top level of the serial command frame parser: sequencer plus datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: rx_byte
//  m_       | out       | m_tvalid/m_tready  | m_tuser: kind; m_tdata: frame fields; m_tlast
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_data (no read-back)
//
// Each received byte is taken when s_tvalid and s_tready are both high. A good
// frame (data or clear) emits its results after the ending byte: the data buffer
// is read first, then one result goes out per cycle while the output register is
// free. Input is held off during that burst.
// Count, width and ending bytes wait while the output register is full, since
// they may cause a discard; other bytes are taken regardless.
// Reset returns to hunting for the header and restores the config defaults;
// the data buffer is not cleared (only bytes written in the current frame are read).
module serial_command_frame_parser #(
	parameter int MAX_DATA_BYTES = scfp_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request input: one received byte
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	// result output
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] target_register, [12:8] data_count, [14:13] element_width,
	// [19:15] byte_index, [27:20] byte_value, [31:28] zero
	output logic [scfp_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [scfp_pkg::KIND_W-1:0]         m_tuser,   // [1:0] event_kind
	output logic                                m_tlast,   // last_of_frame
	// configuration writes
	input  logic                                cfg_wr_en,
	input  logic [scfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scfp_pkg::BYTE_W-1:0]         cfg_data
);

	scfp_pkg::ctrl_cmd_t  cmd;
	scfp_pkg::dp_status_t sts;

	logic [scfp_pkg::BYTE_W-1:0]  ev_register;
	logic [scfp_pkg::COUNT_W-1:0] ev_count;
	logic [scfp_pkg::WIDTH_W-1:0] ev_width;
	logic [scfp_pkg::INDEX_W-1:0] ev_index;
	logic [scfp_pkg::BYTE_W-1:0]  ev_value;

	// Phase sequencer: decides what each accepted byte means
	scfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: holds header fields, buffers data bytes, drives the output register
	scfp_datapath #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rx_byte     (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.ev_kind     (m_tuser),
		.ev_register (ev_register),
		.ev_count    (ev_count),
		.ev_width    (ev_width),
		.ev_index    (ev_index),
		.ev_value    (ev_value),
		.ev_last     (m_tlast)
	);

	// Pack result fields, lowest first, zero pad to a whole byte
	assign m_tdata = {4'b0000, ev_value, ev_index, ev_width, ev_count, ev_register};

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the serial command frame parser.
`timescale 1ns / 100ps

module tb_top;

	localparam int MAX_BYTES = scfp_pkg::MAX_DATA_BYTES_DEF;
	// The index port is two bits wide; index 3 addresses no register.
	localparam logic [scfp_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int STALL_CYCLES = 400;
	localparam int SETTLE_CYCLES = 30;

	typedef enum logic [2:0] {
		HUNT_HDR, GET_REG, GET_COUNT, GET_WIDTH, GET_DATA, GET_END
	} parse_phase_t;

	typedef struct packed {
		logic [scfp_pkg::KIND_W-1:0]  kind;
		logic [scfp_pkg::BYTE_W-1:0]  tgt;
		logic [scfp_pkg::COUNT_W-1:0] count;
		logic [scfp_pkg::WIDTH_W-1:0] width;
		logic [scfp_pkg::INDEX_W-1:0] index;
		logic [scfp_pkg::BYTE_W-1:0]  value;
		logic                         last;
	} frame_event_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [scfp_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [scfp_pkg::KIND_W-1:0]     m_tuser;
	logic                            m_tlast;
	logic                            cfg_wr_en = 1'b0;
	logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [scfp_pkg::BYTE_W-1:0]     cfg_data = '0;

	serial_command_frame_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stimulus side: bytes waiting to be offered, and the register values
	// the generator builds frames around.
	logic [7:0]   rx_pending[$];
	logic [7:0]   hdr_now = scfp_pkg::HEADER_RST;
	logic [7:0]   end_now = scfp_pkg::ENDING_RST;
	logic [7:0]   clr_now = scfp_pkg::CLEAR_RST;
	bit           byte_taken = 1'b0;
	bit           sender_gaps = 1'b0;
	bit           receiver_gaps = 1'b0;
	bit           long_stall_req = 1'b0;
	bit           long_stall_done = 1'b0;
	int           stall_left = 0;

	// Parser mirror: its own registers and frame state, updated per accepted byte.
	logic [7:0]                   hdr_cfg = scfp_pkg::HEADER_RST;
	logic [7:0]                   end_cfg = scfp_pkg::ENDING_RST;
	logic [7:0]                   clr_cfg = scfp_pkg::CLEAR_RST;
	parse_phase_t                 phase = HUNT_HDR;
	logic [7:0]                   frame_reg = '0;
	logic [scfp_pkg::COUNT_W-1:0] frame_count = '0;
	logic [scfp_pkg::WIDTH_W-1:0] frame_width = '0;
	logic [scfp_pkg::INDEX_W-1:0] fill = '0;
	logic [7:0]                   frame_buf[MAX_BYTES];
	frame_event_t                 pending_events[$];

	int mismatches = 0;
	int bytes_taken = 0;
	int events_seen = 0;
	int kind_seen[3] = '{0, 0, 0};

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic frame_event_t make_event(input logic [scfp_pkg::KIND_W-1:0] kind,
		input logic [scfp_pkg::INDEX_W-1:0] idx, input logic [7:0] val, input logic last);
		frame_event_t ev;
		ev.kind  = kind;
		ev.tgt   = frame_reg;
		ev.count = frame_count;
		ev.width = frame_width;
		ev.index = idx;
		ev.value = val;
		ev.last  = last;
		return ev;
	endfunction

	// Advance the frame parser by one received byte and queue the events it raises.
	task automatic parse_rx_byte(input logic [7:0] b);
		int n;
		case (phase)
			GET_REG: begin
				frame_reg = b;
				phase = GET_COUNT;
			end
			GET_COUNT: begin
				if ((b == scfp_pkg::COUNT_SHORT || b == scfp_pkg::COUNT_PAIR
						|| b == scfp_pkg::COUNT_LONG) && b <= MAX_BYTES) begin
					frame_count = b[scfp_pkg::COUNT_W-1:0];
					phase = GET_WIDTH;
				end else begin
					pending_events.push_back(make_event(scfp_pkg::EV_DISCARD, '0, b, 1'b1));
					phase = HUNT_HDR;
				end
			end
			GET_WIDTH: begin
				if (b > scfp_pkg::WIDTH_LIMIT) begin
					pending_events.push_back(make_event(scfp_pkg::EV_DISCARD, '0, b, 1'b1));
					phase = HUNT_HDR;
				end else begin
					frame_width = b[scfp_pkg::WIDTH_W-1:0];
					fill = '0;
					phase = GET_DATA;
				end
			end
			GET_DATA: begin
				// header-valued bytes land here as plain data
				if (fill < MAX_BYTES)
					frame_buf[fill] = b;
				fill = fill + 1'b1;
				if (fill >= frame_count)
					phase = GET_END;
			end
			GET_END: begin
				// ending check comes first, then the clear-register shape check
				if (b != end_cfg) begin
					pending_events.push_back(make_event(scfp_pkg::EV_DISCARD, '0, b, 1'b1));
				end else if (frame_reg == clr_cfg) begin
					if (frame_count != scfp_pkg::CLEAR_COUNT
							|| frame_width != scfp_pkg::CLEAR_WIDTH)
						pending_events.push_back(make_event(scfp_pkg::EV_DISCARD, '0, b,
							1'b1));
					else
						pending_events.push_back(make_event(scfp_pkg::EV_CLEAR, '0,
							frame_buf[0], 1'b1));
				end else begin
					for (n = 0; n < frame_count && n < MAX_BYTES; n++)
						pending_events.push_back(make_event(scfp_pkg::EV_DATA,
							n[scfp_pkg::INDEX_W-1:0], frame_buf[n], (n + 1 == frame_count)));
				end
				phase = HUNT_HDR;
			end
			default: begin
				if (b == hdr_cfg) begin
					frame_reg = '0;
					frame_count = '0;
					frame_width = '0;
					fill = '0;
					phase = GET_REG;
				end
			end
		endcase
	endtask

	// Compare one delivered result against the oldest pending event.
	task automatic check_event();
		frame_event_t want;
		events_seen++;
		if (m_tuser < 3)
			kind_seen[m_tuser]++;
		if (pending_events.size() == 0) begin
			report_mismatch("unexpected result, kind", m_tuser, -1);
		end else begin
			want = pending_events.pop_front();
			if (m_tuser != want.kind)
				report_mismatch("event_kind", m_tuser, want.kind);
			if (m_tdata[7:0] != want.tgt)
				report_mismatch("target_register", m_tdata[7:0], want.tgt);
			if (m_tdata[12:8] != want.count)
				report_mismatch("data_count", m_tdata[12:8], want.count);
			if (m_tdata[14:13] != want.width)
				report_mismatch("element_width", m_tdata[14:13], want.width);
			if (m_tdata[19:15] != want.index)
				report_mismatch("byte_index", m_tdata[19:15], want.index);
			if (m_tdata[27:20] != want.value)
				report_mismatch("byte_value", m_tdata[27:20], want.value);
			if (m_tlast != want.last)
				report_mismatch("last_of_frame", m_tlast, want.last);
			if (m_tdata[31:28] != '0)
				report_mismatch("tdata padding", m_tdata[31:28], 0);
		end
	endtask

	// Monitor: sample both handshakes and the config port at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					scfp_pkg::CFG_HEADER: hdr_cfg = cfg_data;
					scfp_pkg::CFG_ENDING: end_cfg = cfg_data;
					scfp_pkg::CFG_CLEAR:  clr_cfg = cfg_data;
					default: ;  // drop writes to the unused index
				endcase
			end
			if (s_tvalid && s_tready) begin
				parse_rx_byte(s_tdata);
				bytes_taken++;
				byte_taken = 1'b1;
			end
			if (m_tvalid && m_tready)
				check_event();
		end
	end

	// Driver: hold a request until it is taken, then offer the next one or idle.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || byte_taken)) begin
			byte_taken = 1'b0;
			if (rx_pending.size() != 0 && !(sender_gaps && $urandom_range(99, 0) < 12)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= rx_pending.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_stall_req && !long_stall_done) begin
			long_stall_done = 1'b1;
			stall_left = STALL_CYCLES;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(receiver_gaps && $urandom_range(99, 0) < 12);
		end
	end

	task automatic write_reg(input logic [scfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			scfp_pkg::CFG_HEADER: hdr_now = val;
			scfp_pkg::CFG_ENDING: end_now = val;
			scfp_pkg::CFG_CLEAR:  clr_now = val;
			default: ;
		endcase
	endtask

	// Wait until every request is taken and every result has come, then let
	// the parser settle before the next register write.
	task automatic wait_idle();
		while (rx_pending.size() != 0 || s_tvalid || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_count();
		int r;
		r = $urandom_range(99, 0);
		if (r < 15)
			return int'(scfp_pkg::COUNT_LONG);
		return (r < 57) ? int'(scfp_pkg::COUNT_SHORT) : int'(scfp_pkg::COUNT_PAIR);
	endfunction

	// Queue one frame with random data; some data bytes mimic the header.
	task automatic queue_frame(input logic [7:0] tgt, input int cnt, input int wid,
		input bit good_end, output int len);
		logic [7:0] closing;
		rx_pending.push_back(hdr_now);
		rx_pending.push_back(tgt);
		rx_pending.push_back(cnt[7:0]);
		rx_pending.push_back(wid[7:0]);
		for (int i = 0; i < cnt; i++)
			rx_pending.push_back(($urandom_range(7, 0) == 0) ? hdr_now
				: 8'($urandom_range(255, 0)));
		closing = end_now;
		if (!good_end)
			do closing = 8'($urandom_range(255, 0)); while (closing == end_now);
		rx_pending.push_back(closing);
		len = cnt + 5;
	endtask

	// Mostly well-formed frames, the rest broken frames and line noise.
	task automatic run_random(input int budget);
		int queued;
		int len;
		int r;
		int cnt;
		int wid;
		int noise_len;
		logic [7:0] tgt;
		logic [7:0] junk;
		queued = 0;
		while (queued < budget) begin
			r = $urandom_range(99, 0);
			tgt = ($urandom_range(9, 0) == 0) ? clr_now : 8'($urandom_range(255, 0));
			cnt = pick_count();
			wid = $urandom_range(2, 0);
			if (tgt == clr_now && $urandom_range(9, 0) < 6) begin
				cnt = int'(scfp_pkg::CLEAR_COUNT);
				wid = int'(scfp_pkg::CLEAR_WIDTH);
			end
			if (r < 55) begin
				queue_frame(tgt, cnt, wid, 1'b1, len);
				queued += len;
			end else if (r < 65) begin
				queue_frame(tgt, cnt, wid, 1'b0, len);
				queued += len;
			end else if (r < 75) begin
				do junk = 8'($urandom_range(255, 0));
				while (junk == scfp_pkg::COUNT_SHORT || junk == scfp_pkg::COUNT_PAIR
					|| junk == scfp_pkg::COUNT_LONG);
				rx_pending.push_back(hdr_now);
				rx_pending.push_back(tgt);
				rx_pending.push_back(junk);
				queued += 3;
			end else if (r < 85) begin
				rx_pending.push_back(hdr_now);
				rx_pending.push_back(tgt);
				rx_pending.push_back(cnt[7:0]);
				rx_pending.push_back(8'($urandom_range(255,
					int'(scfp_pkg::WIDTH_LIMIT) + 1)));
				queued += 4;
			end else begin
				// noise while hunting; never the header, so it is simply dropped
				noise_len = $urandom_range(4, 1);
				repeat (noise_len) begin
					do junk = 8'($urandom_range(255, 0)); while (junk == hdr_now);
					rx_pending.push_back(junk);
				end
				queued += noise_len;
			end
		end
	endtask

	// Opening frames at reset settings: a clear, a bad count, a bad width,
	// a width-0 frame carrying the header as data, and a bad ending.
	task automatic queue_opening();
		logic [7:0] opening[26];
		opening = '{
			8'hAA, 8'h00, 8'h01, 8'h01, 8'hFF, 8'h55,
			8'hAA, 8'h07, 8'hFF,
			8'hAA, 8'h05, 8'h02, 8'h03,
			8'hAA, 8'hFF, 8'h02, 8'h00, 8'hAA, 8'h00, 8'h55,
			8'hAA, 8'h10, 8'h01, 8'h02, 8'h12, 8'h54
		};
		foreach (opening[i])
			rx_pending.push_back(opening[i]);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		queue_opening();
		wait_idle();

		// A write to the spare index must leave every register alone.
		write_reg(CFG_SPARE, 8'h3C);
		run_random(115);
		long_stall_req = 1'b1;
		wait_idle();

		// Extremes, with both sides running flat out.
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		write_reg(scfp_pkg::CFG_HEADER, 8'h00);
		write_reg(scfp_pkg::CFG_ENDING, 8'hFF);
		write_reg(scfp_pkg::CFG_CLEAR, 8'hFF);
		run_random(115);
		wait_idle();

		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		write_reg(scfp_pkg::CFG_HEADER, 8'hFF);
		write_reg(scfp_pkg::CFG_ENDING, 8'h00);
		write_reg(scfp_pkg::CFG_CLEAR, 8'h7E);
		run_random(115);
		wait_idle();

		if (pending_events.size() != 0)
			report_mismatch("results never delivered", 0, pending_events.size());
		$display("Parsed %0d bytes into %0d results (%0d data, %0d clear, %0d discard)",
			bytes_taken, events_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
		$display("across three register settings, a spare-index write, random gaps");
		$display("and one long output hold-off");
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("run did not finish in time");
		$display("TEST FAILED");
		$finish;
	end

endmodule
